### hdl/imh_pkg.sv
`default_nettype none
package imh_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int KIND_W   = 1;
  localparam int SLOT_W   = 9;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_UPSERT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_LOAD_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {POS_HOLD, POS_SLOT, POS_COUNT, POS_PARENT} pos_sel_t;
  typedef enum logic [1:0] {RD_NONE, RD_LAST, RD_PARENT, RD_CHILDREN} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_PARENT, WR_BEST, WR_CUR} wr_sel_t;
  typedef enum logic [2:0] {EM_NONE, EM_MOVE, EM_FINAL, EM_FULL, EM_BAD} emit_t;

  typedef struct packed {
    logic     latch;
    logic     load_last;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     pos_best;
    pos_sel_t pos_sel;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    emit_t    emit;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic slot_lt_count;
    logic count_full;
    logic slot_is_last;
    logic pos_zero;
    logic parent_gt;
    logic child_wins;
  } stat_t;

endpackage
`default_nettype wire

### hdl/imh_ctrl.sv
`default_nettype none
module imh_ctrl
  import imh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   up_r, up_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      up_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      up_r    <= up_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    up_nxt    = up_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          up_nxt    = 1'b0;
          if (stat.kind == KIND_UPSERT) begin
            if (stat.slot_lt_count) begin
              cmd.pos_sel = POS_SLOT;
              state_nxt   = S_UP_RD;
            end else if (stat.count_full) begin
              cmd.emit = EM_FULL;
            end else begin
              cmd.pos_sel = POS_COUNT;
              cmd.cnt_inc = 1'b1;
              state_nxt   = S_UP_RD;
            end
          end else begin
            if (!stat.slot_lt_count) begin
              cmd.emit = EM_BAD;
            end else begin
              cmd.cnt_dec = 1'b1;
              if (!stat.slot_is_last) begin
                cmd.pos_sel = POS_SLOT;
                state_nxt   = S_RD_LAST;
              end
            end
          end
        end
      end
      S_RD_LAST: begin
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_LOAD_LAST;
      end
      S_LOAD_LAST: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_UP_RD;
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          state_nxt = up_r ? S_FINAL : S_DN_RD;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_gt) begin
          cmd.wr_sel  = WR_PARENT;
          cmd.emit    = EM_MOVE;
          cmd.pos_sel = POS_PARENT;
          up_nxt      = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          state_nxt = up_r ? S_FINAL : S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd.rd_sel = RD_CHILDREN;
        state_nxt  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.child_wins) begin
          cmd.wr_sel   = WR_BEST;
          cmd.emit     = EM_MOVE;
          cmd.pos_best = 1'b1;
          state_nxt    = S_DN_RD;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.wr_sel = WR_CUR;
        cmd.emit   = EM_FINAL;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/imh_datapath.sv
`default_nettype none
module imh_datapath
  import imh_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [KEY_W-1:0]    in_key_value,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output logic                     out_valid,
  output logic [HANDLE_W-1:0]      out_moved_handle,
  output logic [POS_W-1:0]         out_new_position,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic                     out_last
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IW     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

  logic [KEY_W-1:0]       key_mem [CAPACITY];
  logic [HANDLE_BITS-1:0] hdl_mem [CAPACITY];

  logic [CNT_W-1:0]       count_r;
  logic [ADDR_W-1:0]      pos_r;
  logic [KEY_W-1:0]       cur_key_r;
  logic [HANDLE_BITS-1:0] cur_hdl_r;
  logic [KEY_W-1:0]       key_a_r, key_b_r;
  logic [HANDLE_BITS-1:0] hdl_a_r, hdl_b_r;

  logic                   out_valid_r;
  logic [HANDLE_W-1:0]    out_hdl_r;
  logic [POS_W-1:0]       out_pos_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_last_r;

  logic [IW-1:0]          slot_ext, cnt_ext, l_idx, r_idx;
  logic [ADDR_W-1:0]      parent, best_pos, rd_addr_a, rd_addr_b;
  logic                   l_ok, r_ok, take_l, take_r, rd_en;
  logic [KEY_W-1:0]       wr_key;
  logic [HANDLE_BITS-1:0] wr_hdl;

  assign slot_ext = IW'(in_slot);
  assign cnt_ext  = IW'(count_r);
  assign l_idx    = (IW'(pos_r) << 1) + IW'(1);
  assign r_idx    = (IW'(pos_r) << 1) + IW'(2);
  assign parent   = (pos_r - ADDR_W'(1)) >> 1;
  assign l_ok     = l_idx < cnt_ext;
  assign r_ok     = r_idx < cnt_ext;
  assign take_l   = l_ok && (key_a_r < cur_key_r);
  assign take_r   = r_ok && (take_l ? (key_b_r < key_a_r) : (key_b_r < cur_key_r));
  assign best_pos = take_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

  always_comb begin
    stat.kind          = in_kind;
    stat.slot_lt_count = slot_ext < cnt_ext;
    stat.count_full    = cnt_ext >= IW'(CAPACITY);
    stat.slot_is_last  = (slot_ext + IW'(1)) == cnt_ext;
    stat.pos_zero      = (pos_r == '0);
    stat.parent_gt     = key_a_r > cur_key_r;
    stat.child_wins    = take_l || take_r;
  end

  always_comb begin
    rd_en     = 1'b1;
    rd_addr_a = l_idx[ADDR_W-1:0];
    rd_addr_b = r_idx[ADDR_W-1:0];
    unique case (cmd.rd_sel)
      RD_LAST:     rd_addr_a = count_r[ADDR_W-1:0];
      RD_PARENT:   rd_addr_a = parent;
      RD_CHILDREN: rd_addr_a = l_idx[ADDR_W-1:0];
      RD_NONE:     rd_en     = 1'b0;
      default:     rd_en     = 1'b0;
    endcase
  end

  always_comb begin
    wr_key = cur_key_r;
    wr_hdl = cur_hdl_r;
    unique case (cmd.wr_sel)
      WR_PARENT: begin
        wr_key = key_a_r;
        wr_hdl = hdl_a_r;
      end
      WR_BEST: begin
        wr_key = take_r ? key_b_r : key_a_r;
        wr_hdl = take_r ? hdl_b_r : hdl_a_r;
      end
      WR_CUR, WR_NONE: begin
        wr_key = cur_key_r;
        wr_hdl = cur_hdl_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      key_mem[pos_r] <= wr_key;
      hdl_mem[pos_r] <= wr_hdl;
    end
    if (rd_en) begin
      key_a_r <= key_mem[rd_addr_a];
      hdl_a_r <= hdl_mem[rd_addr_a];
      key_b_r <= key_mem[rd_addr_b];
      hdl_b_r <= hdl_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_key_r <= in_key_value;
      cur_hdl_r <= HANDLE_BITS'(in_handle);
    end else if (cmd.load_last) begin
      cur_key_r <= key_a_r;
      cur_hdl_r <= hdl_a_r;
    end
    if (cmd.pos_best) begin
      pos_r <= best_pos;
    end else begin
      unique case (cmd.pos_sel)
        POS_SLOT:   pos_r <= slot_ext[ADDR_W-1:0];
        POS_COUNT:  pos_r <= count_r[ADDR_W-1:0];
        POS_PARENT: pos_r <= parent;
        POS_HOLD:   pos_r <= pos_r;
        default:    pos_r <= pos_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EM_NONE);
    end
    out_count_r <= COUNT_W'(count_r);
    unique case (cmd.emit)
      EM_MOVE, EM_FINAL: begin
        out_hdl_r    <= HANDLE_W'(wr_hdl);
        out_pos_r    <= POS_W'(pos_r);
        out_status_r <= ST_OK;
        out_last_r   <= (cmd.emit == EM_FINAL);
      end
      EM_FULL: begin
        out_hdl_r    <= '0;
        out_pos_r    <= '0;
        out_status_r <= ST_FULL;
        out_last_r   <= 1'b1;
      end
      EM_BAD: begin
        out_hdl_r    <= '0;
        out_pos_r    <= '0;
        out_status_r <= ST_BAD_SLOT;
        out_last_r   <= 1'b1;
      end
      EM_NONE: ;
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_moved_handle = out_hdl_r;
  assign out_new_position = out_pos_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

### hdl/indexed_min_heap_unit.sv
// Error results are registered and appear in the cycle after start is taken. A sift works
// level by level, each level being one memory read step and one compare/move step.
// One operation at a time: start is taken again only once busy is low.
// The receiver cannot stall.
// Reset: synchronous rst_n clears the entry count and control; heap storage is not cleared.
`default_nettype none
module indexed_min_heap_unit
  import imh_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [KEY_W-1:0]    in_key_value,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output logic                     out_valid,
  output logic [HANDLE_W-1:0]      out_moved_handle,
  output logic [POS_W-1:0]         out_new_position,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic                     out_last
);

  cmd_t  cmd;
  stat_t stat;

  imh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  imh_datapath #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_key_value     (in_key_value),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_moved_handle (out_moved_handle),
    .out_new_position (out_new_position),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  // more results of the same transfer are still to come
  a_move_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("non-final result while idle");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last) else $error("error result not last");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without start");

endmodule
`default_nettype wire

### tb/sv/indexed_min_heap_unit_tb.sv
`default_nettype none
module indexed_min_heap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imh_pkg::*;

  localparam int CAP        = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN      = 40;

  typedef struct {
    logic [HANDLE_W-1:0] moved_handle;
    logic [POS_W-1:0]    new_position;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } move_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0]   in_kind = KIND_UPSERT;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [KEY_W-1:0]    in_key_value = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_moved_handle;
  logic [POS_W-1:0]    out_new_position;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_last;

  indexed_min_heap_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_slot(in_slot), .in_key_value(in_key_value),
    .in_handle(in_handle), .out_valid(out_valid),
    .out_moved_handle(out_moved_handle), .out_new_position(out_new_position),
    .out_status(out_status), .out_entry_count(out_entry_count), .out_last(out_last)
  );

  always #6 clk = ~clk;

  // heap shadow
  logic [KEY_W-1:0]    hkey [CAP];
  logic [HANDLE_W-1:0] hhnd [CAP];
  int unsigned         hcount = 0;
  move_t               pending_moves[$];
  int                  errors = 0;
  int                  cycles = 0;
  bit                  quiet = 0;

  task automatic report(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch %s: got %0h exp %0h (t=%0t)", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void note_move(int unsigned h, int unsigned pos,
                                    logic [STATUS_W-1:0] st, bit lst);
    move_t m;
    m.moved_handle = HANDLE_W'(h);
    m.new_position = POS_W'(pos);
    m.status       = st;
    m.entry_count  = COUNT_W'(hcount);
    m.last         = lst;
    pending_moves.insert(pending_moves.size(), m);
  endfunction

  function automatic void sift_up(int unsigned pos);
    logic [KEY_W-1:0] k;
    logic [HANDLE_W-1:0] h;
    int unsigned par;
    k = hkey[pos];
    h = hhnd[pos];
    while (pos > 0) begin
      par = (pos + 1) / 2 - 1;
      if (!(hkey[par] > k)) break;
      hkey[pos] = hkey[par];
      hhnd[pos] = hhnd[par];
      note_move(hhnd[pos], pos, ST_OK, 0);
      pos = par;
    end
    hkey[pos] = k;
    hhnd[pos] = h;
    note_move(h, pos, ST_OK, 1);
  endfunction

  function automatic void sift_down(int unsigned pos);
    logic [KEY_W-1:0] k, bk;
    logic [HANDLE_W-1:0] h;
    int unsigned l, r, b;
    k = hkey[pos];
    h = hhnd[pos];
    forever begin
      l = pos * 2 + 1;
      r = pos * 2 + 2;
      b = pos;
      bk = k;
      if (l < hcount && hkey[l] < bk) begin
        b = l;
        bk = hkey[l];
      end
      if (r < hcount && hkey[r] < bk) begin
        b = r;
        bk = hkey[r];
      end
      if (b == pos) break;
      hkey[pos] = hkey[b];
      hhnd[pos] = hhnd[b];
      note_move(hhnd[pos], pos, ST_OK, 0);
      pos = b;
    end
    hkey[pos] = k;
    hhnd[pos] = h;
    note_move(h, pos, ST_OK, 1);
  endfunction

  function automatic void resift(int unsigned pos);
    if (pos > 0 && hkey[(pos + 1) / 2 - 1] > hkey[pos]) sift_up(pos);
    else sift_down(pos);
  endfunction

  function automatic void heap_apply(logic [KIND_W-1:0] kind, int unsigned slot,
                                     logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] h);
    int unsigned pos;
    if (kind == KIND_UPSERT) begin
      if (slot < hcount) pos = slot;
      else if (hcount >= CAP) begin
        note_move(0, 0, ST_FULL, 1);
        return;
      end else begin
        pos = hcount;
        hcount++;
      end
      hkey[pos] = key;
      hhnd[pos] = h;
      resift(pos);
    end else begin
      if (hcount == 0 || slot >= hcount) begin
        note_move(0, 0, ST_BAD_SLOT, 1);
        return;
      end
      hcount--;
      hkey[slot] = hkey[hcount];
      hhnd[slot] = hhnd[hcount];
      if (slot < hcount) resift(slot);
    end
  endfunction

  // one transfer; called at a falling edge, returns at a falling edge
  task automatic send(op_row_t r);
    move_t m;
    in_kind = r.kind;
    in_slot = r.slot;
    in_key_value = r.key;
    in_handle = r.handle;
    start = 1'b1;
    do @(posedge clk); while (busy);
    heap_apply(r.kind, r.slot, r.key, r.handle);
    if (r.typed) begin
      m.moved_handle = '0;
      m.new_position = '0;
      m.status = r.status;
      m.entry_count = r.entry_count;
      m.last = 1'b1;
      pending_moves[pending_moves.size() - 1] = m;
    end
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 2))
      0: return KEY_W'($urandom_range(0, 7));
      1: return {$urandom, $urandom};
      default: return $urandom_range(0, 1) ? '1 : {32'h0, $urandom};
    endcase
  endfunction

  function automatic op_row_t rand_op(int erase_pct);
    op_row_t r;
    r.typed = 0;
    r.key = rand_key();
    r.handle = HANDLE_W'($urandom);
    r.kind = ($urandom_range(0, 99) < erase_pct) ? KIND_ERASE : KIND_UPSERT;
    if (hcount > 0 && $urandom_range(0, 9) < 8) r.slot = SLOT_W'($urandom_range(0, hcount - 1));
    else r.slot = SLOT_W'($urandom_range(hcount, 511));
    if ($urandom_range(0, 15) == 0) r.slot = SLOT_W'($urandom_range(0, 511));
    return r;
  endfunction

  always @(posedge clk) begin
    move_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_moves.size() == 0) report("unexpected result", out_moved_handle, 0);
      else begin
        e = pending_moves.pop_front();
        if (out_moved_handle !== e.moved_handle)
          report("moved_handle", out_moved_handle, e.moved_handle);
        if (out_new_position !== e.new_position)
          report("new_position", out_new_position, e.new_position);
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_entry_count !== e.entry_count)
          report("entry_count", out_entry_count, e.entry_count);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  op_row_t directed[] = '{
    '{KIND_ERASE,  9'd0,   64'd0,  16'h0000, 1, ST_BAD_SLOT, 9'd0},
    '{KIND_UPSERT, 9'd0,   64'd50, 16'h0001, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd256, '1,     16'hffff, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd511, 64'd0,  16'h0000, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd3,   64'd20, 16'h0002, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd4,   64'd20, 16'h0003, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd5,   64'd10, 16'h8000, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd0,   '1,     16'h7fff, 0, ST_OK, 9'd0},
    '{KIND_UPSERT, 9'd2,   64'd0,  16'h5555, 0, ST_OK, 9'd0},
    '{KIND_ERASE,  9'd5,   '1,     16'hffff, 0, ST_OK, 9'd0},
    '{KIND_ERASE,  9'd0,   64'd0,  16'h0000, 0, ST_OK, 9'd0},
    '{KIND_ERASE,  9'd1,   64'd0,  16'h0000, 0, ST_OK, 9'd0},
    '{KIND_ERASE,  9'd200, 64'd0,  16'h0000, 1, ST_BAD_SLOT, 9'd3},
    '{KIND_ERASE,  9'd511, 64'd0,  16'h0000, 1, ST_BAD_SLOT, 9'd3},
    '{KIND_UPSERT, 9'd1,   64'd1,  16'haaaa, 0, ST_OK, 9'd0}
  };

  initial begin
    op_row_t r;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i]) send(directed[i]);
    repeat (12) send(rand_op(35));
    start = 1'b0;
    while (pending_moves.size() != 0) @(negedge clk);
    // fill to capacity by appends, then overflow
    while (hcount < CAP) begin
      r = rand_op(0);
      r.slot = SLOT_W'($urandom_range(hcount, 511));
      send(r);
    end
    repeat (3) begin
      r = rand_op(0);
      r.slot = SLOT_W'($urandom_range(CAP, 511));
      r.typed = 1;
      r.status = ST_FULL;
      r.entry_count = COUNT_W'(CAP);
      send(r);
    end
    repeat (10) send(rand_op(70));
    quiet = 1;
    repeat (10) send(rand_op(50));
    start = 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
